>>> hdl/rlsfb_pkg.sv
// ----------------------------------------------------------------------------
// rlsfb_pkg
// Shared types, frame constants and the bit-to-nibble encoder of the LED
// frame buffer.
// ----------------------------------------------------------------------------
package rlsfb_pkg;

    localparam int IN_W          = 40;  // stream input tdata width
    localparam int IN_USER_W     = 3;   // stream input tuser width
    localparam int OUT_W         = 8;   // stream output tdata width
    localparam int COLOR_W       = 24;  // packed G, R, B
    localparam int ENTRY_W       = COLOR_W + 1;  // written mark on top
    localparam int HEADER_BYTES  = 2;
    localparam int BYTES_PER_LED = 12;

    // k / 12 == (k * 171) >> 11 for every 8-bit k
    localparam int DIV12_MUL   = 171;
    localparam int DIV12_SHIFT = 11;

    typedef enum logic [2:0] {
        REQ_SET_ONE = 3'd0,
        REQ_SET_ALL = 3'd1,
        REQ_CLEAR   = 3'd2,
        REQ_ROTATE  = 3'd3,
        REQ_READ    = 3'd4
    } t_req_type;

    // Two color bits, MSB first, become two nibbles: 1000 for 0, 1100 for 1.
    function automatic logic [7:0] encode_byte(input logic [COLOR_W-1:0] grb,
                                               input logic [3:0] pair_idx);
        logic [4:0] pos;
        logic       hi;
        logic       lo;
        pos = 5'(5'd22 - {pair_idx, 1'b0});
        lo  = grb[pos];
        hi  = grb[5'(pos + 5'd1)];
        return {1'b1, hi, 2'b00, 1'b1, lo, 2'b00};
    endfunction

endpackage

>>> hdl/rlsfb_modadd.sv
// ----------------------------------------------------------------------------
// rlsfb_modadd
// Shared modulo adder: (a + b) mod MOD for operands already below MOD.
// ----------------------------------------------------------------------------
module rlsfb_modadd #(
    parameter int MOD = 16,
    parameter int W   = 4
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_sum
);

    logic [W:0] w_raw;

    always_comb begin
        w_raw = {1'b0, i_a} + {1'b0, i_b};
        if (int'(w_raw) >= MOD) begin
            // wrap once: both operands are below MOD
            o_sum = W'(w_raw - (W+1)'(MOD));
        end else begin
            o_sum = w_raw[W-1:0];
        end
    end

endmodule

>>> hdl/rlsfb_store.sv
// ----------------------------------------------------------------------------
// rlsfb_store
// Color memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rlsfb_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 25
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rgb_led_spi_frame_buffer_core.sv
// ----------------------------------------------------------------------------
// rgb_led_spi_frame_buffer_core
// Frame buffer for a chain of serial RGB LEDs with nibble-encoded SPI frame
// byte reads, set/fill/clear/rotate requests, one result item per request.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata fields, low bit first            tuser
// s_axis    in   led_index[3:0] byte_index[11:4]        req_type[2:0]
//                red[19:12] green[27:20] blue[35:28]
// m_axis    out  frame_byte[7:0]                        bad_request[0]
//
// All address and wrap arithmetic runs through one modulo adder, and the
// color memory has one read and one write port.
// After reset a clearing pass wipes the written marks;
// no item is accepted during it.
// A result waiting on m_axis does not block the next accept; the following
// result holds in its last step until the output register frees.
// ----------------------------------------------------------------------------
module rgb_led_spi_frame_buffer_core #(
    parameter int LED_COUNT = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // led_index, byte_index, red, green, blue
    input  logic [rlsfb_pkg::IN_W-1:0]  i_s_axis_tdata,
    // req_type
    input  logic [rlsfb_pkg::IN_USER_W-1:0] i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // frame_byte
    output logic [rlsfb_pkg::OUT_W-1:0] o_m_axis_tdata,
    // bad_request
    output logic                      o_m_axis_tuser
);

    import rlsfb_pkg::*;

    localparam int SW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int TOTAL = HEADER_BYTES + BYTES_PER_LED * LED_COUNT;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_FILL,
        S_DIV,
        S_CALC,
        S_RD,
        S_ENC,
        S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [2:0]           r_req, n_req;
    logic [SW-1:0]        r_led, n_led;
    logic [7:0]           r_k, n_k;
    logic [3:0]           r_j, n_j;
    logic [COLOR_W-1:0]   r_color, n_color;
    logic [SW-1:0]        r_cnt, n_cnt;
    logic [SW-1:0]        r_base, n_base;
    logic [SW-1:0]        r_addr, n_addr;
    logic [7:0]           r_frame, n_frame;
    logic                 r_bad, n_bad;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_frame, n_out_frame;
    logic                 r_out_bad, n_out_bad;

    // input fields
    logic [2:0]           w_req;
    logic [3:0]           w_led;
    logic [7:0]           w_byte;
    logic [COLOR_W-1:0]   w_grb;
    logic                 w_accept;

    // shared adder and memory ports
    logic [SW-1:0]        w_add_a, w_add_b, w_sum;
    logic                 w_we;
    logic [SW-1:0]        w_waddr;
    logic [ENTRY_W-1:0]   w_wdata;
    logic [ENTRY_W-1:0]   w_rdata;

    // divide by twelve
    logic [15:0]          w_prod;
    logic [4:0]           w_quot;
    logic [7:0]           w_sub;

    assign w_req  = i_s_axis_tuser;
    assign w_led  = i_s_axis_tdata[3:0];
    assign w_byte = i_s_axis_tdata[11:4];
    assign w_grb  = {i_s_axis_tdata[27:20], i_s_axis_tdata[19:12],
                     i_s_axis_tdata[35:28]};

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_frame;
    assign o_m_axis_tuser  = r_out_bad;

    assign w_prod = 16'(r_k) * 16'(DIV12_MUL);
    assign w_quot = w_prod[15:DIV12_SHIFT];
    assign w_sub  = r_k - (8'(w_quot) * 8'(BYTES_PER_LED));

    rlsfb_modadd #(
        .MOD (LED_COUNT),
        .W   (SW)
    ) u_modadd (
        .i_a   (w_add_a),
        .i_b   (w_add_b),
        .o_sum (w_sum)
    );

    rlsfb_store #(
        .DEPTH (LED_COUNT),
        .AW    (SW),
        .DW    (ENTRY_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // adder operand and memory write selection
    always_comb begin
        w_add_a = r_cnt;
        w_add_b = SW'(1);
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = '0;
        unique case (r_state)
            S_CLR: begin
                w_we = 1'b1;
            end
            S_FILL: begin
                w_we    = 1'b1;
                w_wdata = {1'b1, r_color};
            end
            S_CALC: begin
                if (r_req == REQ_ROTATE) begin
                    w_add_a = r_base;
                end else begin
                    w_add_a = r_led;
                    w_add_b = r_base;
                end
                if (r_req == REQ_SET_ONE) begin
                    w_we    = 1'b1;
                    w_waddr = w_sum;
                    w_wdata = {1'b1, r_color};
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_led       = r_led;
        n_k         = r_k;
        n_j         = r_j;
        n_color     = r_color;
        n_cnt       = r_cnt;
        n_base      = r_base;
        n_addr      = r_addr;
        n_frame     = r_frame;
        n_bad       = r_bad;
        n_out_valid = r_out_valid;
        n_out_frame = r_out_frame;
        n_out_bad   = r_out_bad;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                n_cnt = w_sum;
                if (int'(r_cnt) == LED_COUNT - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_req   = w_req;
                    n_frame = 8'd0;
                    n_bad   = 1'b0;
                    n_color = w_grb;
                    n_state = S_DONE;
                    unique case (w_req)
                        REQ_SET_ONE: begin
                            if (int'(w_led) >= LED_COUNT) begin
                                n_bad = 1'b1;
                            end else begin
                                n_led   = SW'(w_led);
                                n_state = S_CALC;
                            end
                        end
                        REQ_SET_ALL, REQ_CLEAR: begin
                            if (w_req == REQ_CLEAR) begin
                                n_color = '0;
                            end
                            n_cnt   = '0;
                            n_state = S_FILL;
                        end
                        REQ_ROTATE: begin
                            n_state = S_CALC;
                        end
                        REQ_READ: begin
                            if (int'(w_byte) >= TOTAL) begin
                                n_bad = 1'b1;
                            end else if (int'(w_byte) >= HEADER_BYTES) begin
                                n_k     = w_byte - 8'(HEADER_BYTES);
                                n_state = S_DIV;
                            end
                        end
                        default: begin
                            // unknown request: zero result, no change
                        end
                    endcase
                end
            end
            S_FILL: begin
                n_cnt = w_sum;
                if (int'(r_cnt) == LED_COUNT - 1) begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                n_led   = SW'(w_quot);
                n_j     = w_sub[3:0];
                n_state = S_CALC;
            end
            S_CALC: begin
                if (r_req == REQ_ROTATE) begin
                    n_base  = w_sum;
                    n_state = S_DONE;
                end else if (r_req == REQ_READ) begin
                    n_addr  = w_sum;
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_ENC;
            end
            S_ENC: begin
                // unwritten slot reads as zero
                if (w_rdata[COLOR_W]) begin
                    n_frame = encode_byte(w_rdata[COLOR_W-1:0], r_j);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_frame = r_frame;
                    n_out_bad   = r_bad;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
        r_req       <= n_req;
        r_led       <= n_led;
        r_k         <= n_k;
        r_j         <= n_j;
        r_color     <= n_color;
        r_addr      <= n_addr;
        r_frame     <= n_frame;
        r_bad       <= n_bad;
        r_out_frame <= n_out_frame;
        r_out_bad   <= n_out_bad;
    end

`ifndef ASSERT_OFF
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_base) < LED_COUNT)
        else $error("rotation base out of range");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) < LED_COUNT)
        else $error("sweep counter out of range");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == 8'd0))
        else $error("bad request carries a nonzero frame byte");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready right after an accepted item");
`endif

endmodule
